[rtl/iame_pkg.sv]
package iame_pkg;

    // Field widths of the stream words.
    localparam int SYM_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int BAD_W    = 8;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_FIELDS = VALUE_W + STATUS_W + BAD_W;
    localparam int OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

    // Parameter defaults.
    localparam int DEF_MAX_NESTING = 16;
    localparam int DEF_VALUE_BITS  = 32;

    // Characters of the expression alphabet.
    localparam logic [SYM_W-1:0] SYM_END   = 8'h00;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;
    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOKEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DEEP  = 2'd3;

endpackage

[rtl/infix_add_mul_evaluator.sv]
// Evaluates an infix expression of single decimal digits, '+', '*' and parentheses, fed one
// character per word on the slave stream and closed by a zero byte. '*' binds tighter than
// '+', and arithmetic wraps modulo 2^VALUE_BITS. At the closing zero byte one result word is
// sent: the value (low 32 bits, zero-extended when narrower) with status 0, or zero with the
// first error seen (1 unexpected token with the offending character, 2 unexpected end,
// 3 nesting deeper than MAX_NESTING); characters after an error are dropped until the zero
// byte. A new word is accepted each cycle while the result register is empty or being drained.
// Saved levels live in a one-port memory with a registered read; the innermost saved level
// is kept in registers, and a ')' fetches the next one so that a following ')' finds it
// ready. The worst path is a ')' that adds the inner sum and product and multiplies by the
// saved product. No clearing pass is needed after reset.
module infix_add_mul_evaluator #(
    parameter int MAX_NESTING = iame_pkg::DEF_MAX_NESTING,
    parameter int VALUE_BITS  = iame_pkg::DEF_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [iame_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [7:0] symbol
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [iame_pkg::OUT_DATA_W-1:0] o_m_tdata    // [31:0] value, [33:32] status,
                                                         // [41:34] bad_symbol
);
    import iame_pkg::*;

    localparam int DW = $clog2(MAX_NESTING + 1);
    localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int VB = VALUE_BITS;

    // Level state.
    logic [VB-1:0]       r_sum, n_sum;
    logic [VB-1:0]       r_prod, n_prod;
    logic                r_want, n_want;
    logic [DW-1:0]       r_depth, n_depth;
    logic [STATUS_W-1:0] r_err, n_err;
    logic [SYM_W-1:0]    r_err_sym, n_err_sym;

    // Innermost saved level, either in registers or in the memory read register.
    logic [VB-1:0] r_top_sum, n_top_sum;
    logic [VB-1:0] r_top_prod, n_top_prod;
    logic          r_top_mem, n_top_mem;
    logic [2*VB-1:0] r_rd_data;
    logic [2*VB-1:0] mem [MAX_NESTING];

    logic [VB-1:0] top_sum, top_prod;
    logic          push, pop_rd;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] depth_m1, depth_m2;

    // Result register.
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [BAD_W-1:0]    r_out_bad, n_out_bad;
    logic                out_load;

    logic             accept;
    logic [SYM_W-1:0] sym;
    logic [VB-1:0]    total;
    logic [VB-1:0]    digit;
    logic [63:0]      total_wide;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign sym        = i_s_tdata[SYM_W-1:0];

    assign top_sum  = r_top_mem ? r_rd_data[2*VB-1:VB] : r_top_sum;
    assign top_prod = r_top_mem ? r_rd_data[VB-1:0]    : r_top_prod;

    assign total      = r_sum + r_prod;
    assign total_wide = 64'(total);
    assign digit      = VB'(sym - SYM_ZERO);
    assign depth_m1   = r_depth - DW'(1);
    assign depth_m2   = r_depth - DW'(2);
    assign wr_addr    = depth_m1[AW-1:0];
    assign rd_addr    = depth_m2[AW-1:0];

    always_comb begin
        n_sum        = r_sum;
        n_prod       = r_prod;
        n_want       = r_want;
        n_depth      = r_depth;
        n_err        = r_err;
        n_err_sym    = r_err_sym;
        n_top_sum    = r_top_sum;
        n_top_prod   = r_top_prod;
        n_top_mem    = r_top_mem;
        push         = 1'b0;
        pop_rd       = 1'b0;
        out_load     = 1'b0;
        n_out_value  = '0;
        n_out_status = r_err;
        n_out_bad    = r_err_sym;

        if (accept) begin
            if (r_err != ST_OK) begin
                // Characters after an error are dropped until the zero byte.
                out_load = (sym == SYM_END);
            end else if (r_want) begin
                if (sym == SYM_OPEN) begin
                    if (r_depth >= DW'(MAX_NESTING)) begin
                        n_err = ST_DEEP;
                    end else begin
                        push       = (r_depth != '0);
                        n_top_sum  = r_sum;
                        n_top_prod = r_prod;
                        n_top_mem  = 1'b0;
                        n_depth    = r_depth + DW'(1);
                        n_sum      = '0;
                        n_prod     = VB'(1);
                    end
                end else if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
                    n_prod = VB'(r_prod * digit);
                    n_want = 1'b0;
                end else if (sym == SYM_END) begin
                    n_err = ST_END;
                end else begin
                    n_err     = ST_TOKEN;
                    n_err_sym = sym;
                end
            end else begin
                if (sym == SYM_STAR) begin
                    n_want = 1'b1;
                end else if (sym == SYM_PLUS) begin
                    n_sum  = total;
                    n_prod = VB'(1);
                    n_want = 1'b1;
                end else if (sym == SYM_CLOSE) begin
                    if (r_depth == '0) begin
                        n_err     = ST_TOKEN;
                        n_err_sym = sym;
                    end else begin
                        n_depth   = depth_m1;
                        n_sum     = top_sum;
                        n_prod    = VB'(top_prod * total);
                        // Fetch the next saved level for a following ')'.
                        pop_rd    = (r_depth >= DW'(2));
                        n_top_mem = 1'b1;
                    end
                end else if (sym == SYM_END) begin
                    if (r_depth != '0) begin
                        n_err = ST_END;
                    end else begin
                        out_load = 1'b1;
                    end
                end else begin
                    n_err     = ST_TOKEN;
                    n_err_sym = sym;
                end
            end

            if (sym == SYM_END) begin
                out_load     = 1'b1;
                n_out_status = n_err;
                n_out_bad    = n_err_sym;
                n_out_value  = (n_err == ST_OK) ? total_wide[VALUE_W-1:0] : '0;
                // Start the next expression afresh.
                n_sum     = '0;
                n_prod    = VB'(1);
                n_want    = 1'b1;
                n_depth   = '0;
                n_err     = ST_OK;
                n_err_sym = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_prod      <= VB'(1);
            r_want      <= 1'b1;
            r_depth     <= '0;
            r_err       <= ST_OK;
            r_err_sym   <= '0;
            r_top_mem   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum     <= n_sum;
            r_prod    <= n_prod;
            r_want    <= n_want;
            r_depth   <= n_depth;
            r_err     <= n_err;
            r_err_sym <= n_err_sym;
            r_top_mem <= n_top_mem;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_sum  <= n_top_sum;
        r_top_prod <= n_top_prod;
        if (out_load) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_bad    <= n_out_bad;
        end
    end

    // Saved-level memory: the innermost level moves here when a deeper one opens.
    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[wr_addr] <= {top_sum, top_prod};
        end
        if (pop_rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_bad, r_out_status, r_out_value});

endmodule

[verif/iame_result_checker.sv]
`timescale 1ns / 100ps

module iame_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [iame_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [7:0] symbol
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [iame_pkg::OUT_DATA_W-1:0] i_m_tdata,   // [31:0] value, [33:32] status,
                                                         // [41:34] bad_symbol
    output int                              o_fail_count,
    output int                              o_pending
);
    import iame_pkg::*;

    localparam int MAX_DEPTH    = DEF_MAX_NESTING;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [BAD_W-1:0]    bad_symbol;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
    } expr_result_t;

    // Evaluation state of the expression in progress.
    logic [VALUE_W-1:0]  run_sum;
    logic [VALUE_W-1:0]  run_product;
    logic                need_operand;
    int                  depth;
    logic [VALUE_W-1:0]  stack_sum [MAX_DEPTH];
    logic [VALUE_W-1:0]  stack_product [MAX_DEPTH];
    logic [STATUS_W-1:0] first_error;
    logic [SYM_W-1:0]    first_bad;

    expr_result_t        awaited_results [$];
    int                  fail_count = 0;

    function automatic void clear_expression();
        run_sum      = '0;
        run_product  = 1;
        need_operand = 1'b1;
        depth        = 0;
        first_error  = ST_OK;
        first_bad    = '0;
    endfunction

    function automatic void note_error(input logic [STATUS_W-1:0] code,
                                       input logic [SYM_W-1:0] sym);
        first_error = code;
        first_bad   = (code == ST_TOKEN) ? sym : '0;
    endfunction

    // Advances the evaluation by one symbol; returns 1 when the symbol closes an expression.
    function automatic bit evaluate_symbol(input logic [SYM_W-1:0] sym,
                                           output expr_result_t res);
        logic [VALUE_W-1:0] digit;
        logic [VALUE_W-1:0] inner;
        res = '0;
        // Once an error is held, everything up to the terminator is dropped.
        if (first_error != ST_OK && sym != SYM_END)
            return 1'b0;
        if (first_error == ST_OK) begin
            if (need_operand) begin
                if (sym == SYM_OPEN) begin
                    if (depth >= MAX_DEPTH) begin
                        note_error(ST_DEEP, sym);
                    end else begin
                        stack_sum[depth]     = run_sum;
                        stack_product[depth] = run_product;
                        depth++;
                        run_sum     = '0;
                        run_product = 1;
                    end
                end else if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
                    digit               = '0;
                    digit[SYM_W-1:0]    = sym - SYM_ZERO;
                    run_product         = run_product * digit;
                    need_operand        = 1'b0;
                end else if (sym == SYM_END) begin
                    note_error(ST_END, sym);
                end else begin
                    note_error(ST_TOKEN, sym);
                end
            end else if (sym == SYM_STAR) begin
                need_operand = 1'b1;
            end else if (sym == SYM_PLUS) begin
                run_sum      = run_sum + run_product;
                run_product  = 1;
                need_operand = 1'b1;
            end else if (sym == SYM_CLOSE) begin
                if (depth == 0) begin
                    note_error(ST_TOKEN, sym);
                end else begin
                    inner       = run_sum + run_product;
                    depth--;
                    run_sum     = stack_sum[depth];
                    run_product = stack_product[depth] * inner;
                end
            end else if (sym == SYM_END) begin
                if (depth != 0) begin
                    note_error(ST_END, sym);
                end else begin
                    res.value = run_sum + run_product;
                    clear_expression();
                    return 1'b1;
                end
            end else begin
                note_error(ST_TOKEN, sym);
            end
        end
        if (sym != SYM_END)
            return 1'b0;
        res.status     = first_error;
        res.bad_symbol = first_bad;
        clear_expression();
        return 1'b1;
    endfunction

    function automatic void flag_mismatch(input string what,
                                          input logic [VALUE_W-1:0] want,
                                          input logic [VALUE_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endfunction

    always @(posedge i_clk) begin
        expr_result_t seen;
        expr_result_t due;
        bit           produced;
        if (!i_rst_n) begin
            clear_expression();
            awaited_results.delete();
        end else begin
            // A result word can only stem from symbols accepted at earlier edges.
            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata[OUT_FIELDS-1:0];
                if (awaited_results.size() == 0) begin
                    flag_mismatch("unsolicited result word", '0, seen.value);
                end else begin
                    due = awaited_results.pop_front();
                    if (seen.value !== due.value)
                        flag_mismatch("value", due.value, seen.value);
                    if (seen.status !== due.status)
                        flag_mismatch("status", VALUE_W'(due.status),
                                      VALUE_W'(seen.status));
                    if (seen.bad_symbol !== due.bad_symbol)
                        flag_mismatch("bad_symbol", VALUE_W'(due.bad_symbol),
                                      VALUE_W'(seen.bad_symbol));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                produced = evaluate_symbol(i_s_tdata[SYM_W-1:0], due);
                if (produced)
                    awaited_results.push_back(due);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_results.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import iame_pkg::*;

    localparam int MAX_DEPTH      = DEF_MAX_NESTING;
    localparam int SYMBOL_TARGET  = 1350;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RUN_LIMIT_NS   = 3_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    pending;

    bit                    rx_hold;
    bit                    tx_steady;
    int                    symbols_sent;
    logic [SYM_W-1:0]      expr_text [$];

    infix_add_mul_evaluator u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    iame_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls per word, runs of full throughput, and one long hold-off.
    initial begin : result_sink
        int stall;
        bit steady;
        steady   = 1'b0;
        m_tready = 1'b0;
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_symbol(input logic [SYM_W-1:0] sym);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        symbols_sent++;
    endtask

    task automatic send_expression();
        tx_steady = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < expr_text.size(); i++)
            send_symbol(expr_text[i]);
        expr_text.delete();
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            expr_text.push_back(text[i]);
        expr_text.push_back(SYM_END);
        send_expression();
    endtask

    // Well-formed body: opens levels up to depth_cap, then closes all that remain open.
    // A cap above the nesting limit lets the too-deep case through.
    task automatic build_nested(input int depth_cap, input int open_pct, input int op_budget);
        int               open_levels;
        int               ops;
        bit               operand_due;
        logic [SYM_W-1:0] digit;
        open_levels = 0;
        ops         = 0;
        operand_due = 1'b1;
        forever begin
            if (operand_due) begin
                if (open_levels < depth_cap && $urandom_range(0, 99) < open_pct) begin
                    expr_text.push_back(SYM_OPEN);
                    open_levels++;
                end else begin
                    // Plenty of nines so that long products wrap.
                    digit = ($urandom_range(0, 2) == 0) ? SYM_NINE
                                                        : SYM_ZERO + SYM_W'($urandom_range(0, 9));
                    expr_text.push_back(digit);
                    operand_due = 1'b0;
                end
            end else if (ops >= op_budget) begin
                break;
            end else if (open_levels > 0 && $urandom_range(0, 99) < 30) begin
                expr_text.push_back(SYM_CLOSE);
                open_levels--;
            end else begin
                expr_text.push_back(($urandom_range(0, 99) < 60) ? SYM_STAR : SYM_PLUS);
                ops++;
                operand_due = 1'b1;
            end
        end
        repeat (open_levels) expr_text.push_back(SYM_CLOSE);
        expr_text.push_back(SYM_END);
    endtask

    // Breaks a finished expression: a stray byte, a cut-off tail, or an inserted symbol.
    task automatic corrupt_expression();
        int               at;
        int               how;
        logic [SYM_W-1:0] stray;
        at    = $urandom_range(0, expr_text.size() - 2);
        how   = $urandom_range(0, 2);
        stray = SYM_W'($urandom_range(0, 255));
        if (how == 0) begin
            expr_text[at] = stray;
        end else if (how == 1) begin
            while (expr_text.size() > at)
                void'(expr_text.pop_back());
            expr_text.push_back(SYM_END);
        end else begin
            expr_text.insert(at, ($urandom_range(0, 1) == 0) ? SYM_CLOSE : stray);
        end
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        int kind;
        int expr_count;
        bit hold_done;
        bit pause_done;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        rst_n        = 1'b0;
        rx_hold      = 1'b0;
        tx_steady    = 1'b0;
        symbols_sent = 0;
        expr_count   = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed expressions: top byte as a stray operand, plain arithmetic, unmatched
        // close, end inside parentheses, empty input, token after an operand, a zero value.
        send_text("\377");
        send_text("9*(8+7)");
        send_text("1)");
        send_text("(1");
        send_text("");
        send_text("2a+");
        send_text("(0)");

        while (symbols_sent < SYMBOL_TARGET) begin
            if (!hold_done && symbols_sent >= 450) begin
                rx_hold   = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && symbols_sent >= 900) begin
                wait_until_drained();
                pause_done = 1'b1;
            end
            // The first two expressions nest one past the limit and exactly to it.
            kind = (expr_count < 2) ? 100 : $urandom_range(0, 99);
            if (kind < 8) begin
                repeat ($urandom_range(1, 10))
                    expr_text.push_back(SYM_W'($urandom_range(0, 255)));
                expr_text.push_back(SYM_END);
            end else begin
                if (expr_count < 2)
                    build_nested(MAX_DEPTH + 1 - expr_count, 100, 4);
                else if (kind < 18)
                    build_nested($urandom_range(MAX_DEPTH - 4, MAX_DEPTH + 1),
                                 $urandom_range(70, 100), $urandom_range(1, 8));
                else
                    build_nested($urandom_range(0, 4), 25, $urandom_range(0, 14));
                if (kind < 100 && $urandom_range(0, 4) == 0)
                    corrupt_expression();
            end
            send_expression();
            expr_count++;
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
